>>> rtl/core/plcr_pkg.sv
// ----------------------------------------------------------------------------
// plcr_pkg
// Shared types and codes of the piecewise linear colour ramp.
// ----------------------------------------------------------------------------
package plcr_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [1:0] REG_LUT_SIZE  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        lut_index;
    logic signed [31:0] point_level;
    logic [15:0]        in_red;
    logic [15:0]        in_green;
    logic [15:0]        in_blue;
    logic [15:0]        in_alpha;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [1:0]  status;
  } out_word_t;

endpackage

>>> rtl/core/plcr_ram.sv
// ----------------------------------------------------------------------------
// plcr_ram
// Generic simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module plcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/plcr_div.sv
// ----------------------------------------------------------------------------
// plcr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcr_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dreg;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [DW:0]     trial;
  logic [DW:0]     sub;
  logic            ge;

  assign trial = {rem, quo[NW-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign sub   = trial - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        dreg <= den;
        cnt  <= CNTW'(NW);
        run  <= 1'b1;
      end else if (run) begin
        quo <= {quo[NW-2:0], ge};
        rem <= ge ? sub[DW-1:0] : trial[DW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/piecewise_linear_colour_ramp_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_colour_ramp_unit
// RGBA colour ramp over a sorted table of control points held in ram.
// ----------------------------------------------------------------------------
// One word is worked on at a time and one result word comes back per input
// word. An insert walks the table from the top down, moving each point above
// the new level up one place until its place is found; an insert on a full
// table is dropped. An evaluate runs the index divide, a four step partial
// product multiply, a point by point scan of the level ram up to the first
// point above x, a second divide for the blend fraction when two points
// bracket x, two colour reads and one channel blend per cycle. The result
// sits in an output register, so the next word is taken while it waits.
// The point rams have no reset; of the table only the point count is cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_colour_ramp_unit
  import plcr_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_DIV1, S_MUL, S_SAT, S_EV_RD, S_EV_CHK,
    S_EV_T, S_DIV2, S_CL, S_CR, S_CW, S_MIX, S_DONE
  } state_t;

  state_t state;

  logic signed [31:0] rng_min, rng_max;
  logic [12:0]        lut_size;

  logic [CW-1:0]      count, k;
  logic [AW-1:0]      left, right;
  logic               have_left;
  logic signed [31:0] llev, rlev, x, nlev;
  logic [63:0]        ncol, cl, cr, res_col;
  logic [1:0]         res_status;
  logic [33:0]        md, mw;
  logic               neg;
  logic [67:0]        acc;
  logic [1:0]         mstep, ch;
  logic [16:0]        t;

  // rams
  logic          lvl_we, col_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   lvl_wdata, lvl_rdata;
  logic [63:0]   col_wdata, col_rdata;

  // divider
  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic [31:0] div_den;

  plcr_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_lvl_ram (
    .clk(clk), .we(lvl_we), .waddr(waddr), .wdata(lvl_wdata),
    .raddr(raddr), .rdata(lvl_rdata)
  );

  plcr_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_col_ram (
    .clk(clk), .we(col_we), .waddr(waddr), .wdata(col_wdata),
    .raddr(raddr), .rdata(col_rdata)
  );

  plcr_div #(.NW(48), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // combinational helpers
  logic [CW-1:0]      km1;
  logic [15:0]        idx_ext;
  logic [12:0]        size_eff;
  logic signed [33:0] d_val, w_val;
  logic [16:0]        mul_a, mul_b;
  logic [33:0]        mul_p;
  logic [6:0]         mul_sh;
  logic [51:0]        mag;
  logic [15:0]        cl_c, cr_c;
  logic signed [16:0] cdiff;
  logic signed [34:0] cprod;
  logic signed [35:0] csum;
  logic               lvl_le;

  assign km1      = k - 1'b1;
  assign idx_ext  = 16'(in_data.lut_index) & 16'((17'd1 << INDEX_BITS) - 17'd1);
  assign size_eff = (lut_size == 13'd0) ? 13'd1 : lut_size;
  assign d_val    = $signed({2'b00, div_quo[31:0]}) - 34'(rng_min);
  assign w_val    = 34'(rng_max) - 34'(rng_min);
  assign mul_a    = mstep[0] ? md[33:17] : md[16:0];
  assign mul_b    = mstep[1] ? mw[33:17] : mw[16:0];
  assign mul_p    = mul_a * mul_b;
  assign mul_sh   = (mstep[0] ? 7'd17 : 7'd0) + (mstep[1] ? 7'd17 : 7'd0);
  assign mag      = acc[67:16];
  assign cl_c     = cl[ch*16 +: 16];
  assign cr_c     = cr[ch*16 +: 16];
  assign cdiff    = $signed({1'b0, cr_c}) - $signed({1'b0, cl_c});
  assign cprod    = cdiff * $signed({1'b0, t});
  assign csum     = $signed({4'b0000, cl_c, 16'h0000}) + 36'(cprod) + 36'sd32768;
  assign lvl_le   = $signed(lvl_rdata) <= x;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    lvl_we    = 1'b0;
    col_we    = 1'b0;
    waddr     = k[AW-1:0];
    lvl_wdata = nlev;
    col_wdata = ncol;
    raddr     = k[AW-1:0];
    div_start = 1'b0;
    div_num   = {16'h0000, idx_ext, 16'h0000};
    div_den   = 32'(size_eff);
    case (state)
      S_IDLE: begin
        div_start = in_valid && in_data.cmd == CMD_EVAL && count != '0;
      end
      S_INS_RD: begin
        raddr = km1[AW-1:0];
        if (k == '0) begin
          lvl_we = 1'b1;
          col_we = 1'b1;
        end
      end
      S_INS_CHK: begin
        lvl_we = 1'b1;
        col_we = 1'b1;
        if ($signed(lvl_rdata) > nlev) begin
          lvl_wdata = lvl_rdata;
          col_wdata = col_rdata;
        end
      end
      S_EV_T: begin
        div_start = state == S_EV_T && right != left;
        div_num   = {32'(x - llev), 16'h0000};
        div_den   = 32'(rlev - llev);
      end
      S_CL: raddr = left;
      S_CR: raddr = right;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rng_min   <= 32'sd0;
      rng_max   <= 32'sd65536;
      lut_size  <= 13'd256;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_MIN: rng_min  <= $signed(cfg_data);
          REG_RANGE_MAX: rng_max  <= $signed(cfg_data);
          REG_LUT_SIZE:  lut_size <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            nlev       <= in_data.point_level;
            ncol       <= {in_data.in_alpha, in_data.in_blue, in_data.in_green,
                           in_data.in_red};
            res_col    <= '0;
            res_status <= STATUS_OK;
            k          <= count;
            if (in_data.cmd == CMD_INSERT) begin
              if (count == CW'(MAX_POINTS)) begin
                res_status <= STATUS_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_INS_RD;
              end
            end else if (count == '0) begin
              res_status <= STATUS_EMPTY;
              state      <= S_DONE;
            end else begin
              state <= S_DIV1;
            end
          end
        end
        S_INS_RD: begin
          if (k == '0) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if ($signed(lvl_rdata) > nlev) begin
            k     <= km1;
            state <= S_INS_RD;
          end else begin
            count <= count + 1'b1;
            state <= S_DONE;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            md    <= d_val[33] ? 34'(-d_val) : d_val;
            mw    <= w_val[33] ? 34'(-w_val) : w_val;
            neg   <= d_val[33] ^ w_val[33];
            acc   <= '0;
            mstep <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc   <= acc + (68'(mul_p) << mul_sh);
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (neg) begin
            x <= (mag >= 52'h80000000) ? 32'sh80000000 : 32'(-mag);
          end else begin
            x <= (mag >= 52'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
          end
          k         <= '0;
          left      <= '0;
          right     <= '0;
          have_left <= 1'b0;
          state     <= S_EV_RD;
        end
        S_EV_RD: state <= S_EV_CHK;
        S_EV_CHK: begin
          if (lvl_le) begin
            left      <= k[AW-1:0];
            right     <= k[AW-1:0];
            llev      <= lvl_rdata;
            have_left <= 1'b1;
            k         <= k + 1'b1;
            state     <= (k + 1'b1 == count) ? S_EV_T : S_EV_RD;
          end else begin
            // first point above x closes the bracket if a point at or below x was found
            if (have_left) begin
              right <= k[AW-1:0];
            end
            rlev  <= lvl_rdata;
            state <= S_EV_T;
          end
        end
        S_EV_T: begin
          t     <= '0;
          state <= (right != left) ? S_DIV2 : S_CL;
        end
        S_DIV2: begin
          if (div_done) begin
            t     <= (div_quo > 48'd65536) ? 17'd65536 : div_quo[16:0];
            state <= S_CL;
          end
        end
        S_CL: state <= S_CR;
        S_CR: begin
          cl    <= col_rdata;
          state <= S_CW;
        end
        S_CW: begin
          cr    <= col_rdata;
          ch    <= 2'd0;
          state <= S_MIX;
        end
        S_MIX: begin
          res_col[ch*16 +: 16] <= csum[31:16];
          ch                   <= ch + 2'd1;
          if (ch == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.out_red   <= res_col[15:0];
            out_data.out_green <= res_col[31:16];
            out_data.out_blue  <= res_col[47:32];
            out_data.out_alpha <= res_col[63:48];
            out_data.status    <= res_status;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
